[rtl/vtb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual timer bank package
// Shared constants, action codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package vtb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TICK_W = 32;
    localparam int COUNT_W = 16;
    localparam int TIMER_SEL_W = 4;
    localparam int ACTION_W = 2;
    localparam logic [TICK_W-1:0] THRESHOLD_RESET = 32'hFFFF_0000;
    localparam logic [TICK_W-1:0] COUNTER_START = 32'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef struct packed {
        logic             load;
        logic             exec;
        logic             walk;
        logic [IDX_W-1:0] walk_idx;
        logic             rebase_done;
        logic             report;
    } vtb_cmd_t;

    typedef struct packed {
        logic rebase_req;
    } vtb_status_t;

    // Folds the raw timer selector onto the bank as a small constant table.
    function automatic logic [IDX_W-1:0] idx_of(input logic [TIMER_SEL_W-1:0] sel);
        logic [IDX_W-1:0] res;
        res = '0;
        for (int k = 0; k < (1 << TIMER_SEL_W); k++) begin
            if (sel == TIMER_SEL_W'(k)) begin
                res = IDX_W'(k % NUM_TIMERS);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/vtb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual timer bank controller
// Sequences capture, update, the rebase walk and the result hand-over.
// ----------------------------------------------------------------------------
module vtb_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    input  vtb_pkg::vtb_status_t  status,
    output vtb_pkg::vtb_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REBASE,
        ST_REPORT
    } state_t;

    state_t                    state_reg, state_next;
    logic [vtb_pkg::IDX_W-1:0] walk_reg, walk_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      walk_last;
    logic                      out_free;

    assign walk_last = (walk_reg == vtb_pkg::IDX_W'(vtb_pkg::NUM_TIMERS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        walk_next     = walk_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.walk_idx  = walk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec  = 1'b1;
                walk_next = '0;
                if (status.rebase_req) begin
                    state_next = ST_REBASE;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_REBASE: begin
                cmd.walk  = 1'b1;
                walk_next = walk_reg + 1'b1;
                if (walk_last) begin
                    cmd.rebase_done = 1'b1;
                    walk_next       = '0;
                    state_next      = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    cmd.report    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            walk_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            walk_reg     <= walk_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_report_not_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> out_free)
        else $error("Result loaded while the previous beat was still pending.");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("Accepted beat was not executed in the following cycle.");

    a_walk_to_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REBASE && walk_last) |=> (state_reg == ST_REPORT && walk_reg == '0))
        else $error("Rebase walk did not finish into the report state.");

endmodule
`default_nettype wire

[rtl/vtb_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual timer bank datapath
// Tick counter, deadline registers, rebase arithmetic and the result register.
// ----------------------------------------------------------------------------
module vtb_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [vtb_pkg::TICK_W-1:0]         cfg_wr_data,
    input  wire  [vtb_pkg::ACTION_W-1:0]       s_action,
    input  wire  [vtb_pkg::TIMER_SEL_W-1:0]    s_timer_index,
    input  wire  [vtb_pkg::TICK_W-1:0]         s_ticks,
    input  vtb_pkg::vtb_cmd_t                  cmd,
    output vtb_pkg::vtb_status_t               status,
    output logic [vtb_pkg::TICK_W-1:0]         m_remaining,
    output logic                               m_elapsed,
    output logic [vtb_pkg::COUNT_W-1:0]        m_restart_count
);

    vtb_pkg::action_t                 action_reg;
    logic [vtb_pkg::IDX_W-1:0]        idx_reg;
    logic [vtb_pkg::TICK_W-1:0]       ticks_reg;
    logic [vtb_pkg::TICK_W-1:0]       threshold_reg;
    logic [vtb_pkg::TICK_W-1:0]       counter_reg, counter_next;
    logic [vtb_pkg::COUNT_W-1:0]      restart_reg, restart_next;
    logic [vtb_pkg::TICK_W-1:0]       deadline_reg [vtb_pkg::NUM_TIMERS];
    logic [vtb_pkg::TICK_W-1:0]       remaining_reg;
    logic                             elapsed_reg;
    logic [vtb_pkg::COUNT_W-1:0]      restart_out_reg;

    logic [vtb_pkg::IDX_W-1:0]        rd_idx;
    logic [vtb_pkg::TICK_W-1:0]       rd_data;
    logic                             dl_wr_en;
    logic [vtb_pkg::TICK_W-1:0]       dl_wr_data;
    logic                             dl_pending;
    logic                             cnt_below;

    assign rd_idx  = cmd.walk ? cmd.walk_idx : idx_reg;
    assign rd_data = deadline_reg[rd_idx];

    assign status.rebase_req = (action_reg == vtb_pkg::ACT_TICK)
                            && (counter_reg >= threshold_reg) && (counter_reg != '1);

    assign dl_pending = rd_data > counter_reg;
    assign cnt_below  = counter_reg < rd_data;

    always_comb begin
        counter_next = counter_reg;
        restart_next = restart_reg;
        dl_wr_en     = 1'b0;
        dl_wr_data   = '0;
        if (cmd.exec) begin
            case (action_reg)
                vtb_pkg::ACT_TICK: begin
                    counter_next = counter_reg + 1'b1;
                end
                vtb_pkg::ACT_SET: begin
                    dl_wr_en   = 1'b1;
                    dl_wr_data = counter_reg + ticks_reg;
                end
                vtb_pkg::ACT_CLEAR: begin
                    dl_wr_en   = 1'b1;
                    dl_wr_data = '0;
                end
                default: begin
                end
            endcase
        end
        if (cmd.walk) begin
            dl_wr_en   = 1'b1;
            dl_wr_data = dl_pending ? (rd_data - counter_reg + vtb_pkg::TICK_W'(1)) : '0;
        end
        if (cmd.rebase_done) begin
            counter_next = vtb_pkg::COUNTER_START;
            restart_next = restart_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= vtb_pkg::THRESHOLD_RESET;
            counter_reg   <= vtb_pkg::COUNTER_START;
            restart_reg   <= '0;
            for (int i = 0; i < vtb_pkg::NUM_TIMERS; i++) begin
                deadline_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            counter_reg <= counter_next;
            restart_reg <= restart_next;
            if (dl_wr_en) begin
                deadline_reg[rd_idx] <= dl_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= vtb_pkg::action_t'(s_action);
            idx_reg    <= vtb_pkg::idx_of(s_timer_index);
            ticks_reg  <= s_ticks;
        end
        if (cmd.report) begin
            remaining_reg   <= cnt_below ? (rd_data - counter_reg) : '0;
            elapsed_reg     <= !cnt_below;
            restart_out_reg <= restart_reg;
        end
    end

    assign m_remaining     = remaining_reg;
    assign m_elapsed       = elapsed_reg;
    assign m_restart_count = restart_out_reg;

    a_rebase_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rebase_done |=> (counter_reg == vtb_pkg::COUNTER_START))
        else $error("Counter did not restart after a rebase.");

    a_restart_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rebase_done |=> (restart_reg == $past(restart_reg) + 16'd1))
        else $error("Restart count did not advance on a rebase.");

endmodule
`default_nettype wire

[rtl/virtual_timer_bank_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Virtual timer bank unit
// Sixteen deadline timers measured against a shared tick counter that starts
// at 1. Each input beat carries an action in tuser (tick, set, clear or query)
// and returns one result beat with the addressed timer's remaining ticks, its
// elapsed flag and the number of counter rebases so far. The unit takes a new
// beat only once the last one is through its steps: capture at acceptance,
// update of the counter or the deadline registers, and the read of the
// addressed timer into the output register. A result still waiting for
// m_tready holds the next beat in its read step. A tick that finds the
// counter at or above the rebase threshold, and not at all ones, starts a
// rebase that walks the deadline registers one timer at a time through their
// single read and write port. Deadlines are cleared by reset directly. The
// threshold is written through cfg_wr_en and cfg_wr_data; the user is to
// write it only while the unit is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module virtual_timer_bank_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // timer_index [3:0], ticks [35:4], zero [39:36]
    input  wire  [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata    // remaining [31:0], elapsed [32],
                                   // restart_count [48:33], zero [55:49]
);

    vtb_pkg::vtb_cmd_t                cmd;
    vtb_pkg::vtb_status_t             status;
    logic [vtb_pkg::TICK_W-1:0]       remaining;
    logic                             elapsed;
    logic [vtb_pkg::COUNT_W-1:0]      restart_count;

    vtb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    vtb_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_action        (s_tuser),
        .s_timer_index   (s_tdata[3:0]),
        .s_ticks         (s_tdata[35:4]),
        .cmd             (cmd),
        .status          (status),
        .m_remaining     (remaining),
        .m_elapsed       (elapsed),
        .m_restart_count (restart_count)
    );

    assign m_tdata = {7'd0, restart_count, elapsed, remaining};

endmodule
`default_nettype wire
